// File: sv/serial_rx_status_fifo_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the serial receive block
// ---------------------------------------------------------------------------
`ifndef SERIAL_RX_STATUS_FIFO_DEFINES_SVH
`define SERIAL_RX_STATUS_FIFO_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define SRX_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define SRX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/srx_fifo_pkg.sv
// ---------------------------------------------------------------------------
// srx_fifo_pkg
// Types and constants for the serial receive status block.
// ---------------------------------------------------------------------------
`default_nettype none

package srx_fifo_pkg;

    localparam int RING_DEPTH = 256;
    localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam logic [RING_AW-1:0] RING_LAST = RING_AW'(RING_DEPTH - 1);

    // Request codes
    localparam logic [2:0] REQ_TICK    = 3'd0;
    localparam logic [2:0] REQ_STATUS  = 3'd1;
    localparam logic [2:0] REQ_DATA_RD = 3'd2;
    localparam logic [2:0] REQ_CTRL_WR = 3'd3;
    localparam logic [2:0] REQ_DATA_WR = 3'd4;
    localparam logic [2:0] REQ_PUSH    = 3'd5;

    localparam logic [7:0]  CTRL_RESET_VAL  = 8'h55;
    localparam logic [15:0] FEED_GAP_RESET  = 16'd2500;
    localparam logic [7:0]  STAT_TDRE       = 8'h02;
    localparam logic [7:0]  STAT_RDRF       = 8'h01;
    localparam logic [7:0]  STAT_IRQ        = 8'h80;
    localparam logic [1:0]  CTRL_MASTER_RST = 2'b11;
    localparam int          CTRL_RIE_BIT    = 7;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] bus_data;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_value;
        logic       irq;
        logic       push_dropped;
    } t_out_item;

    function automatic logic [RING_AW-1:0] ring_next(input logic [RING_AW-1:0] idx);
        logic [RING_AW-1:0] nxt;
        nxt = (idx == RING_LAST) ? '0 : idx + RING_AW'(1);
        return nxt;
    endfunction

endpackage

`default_nettype wire

// File: sv/serial_rx_status_fifo.sv
// ---------------------------------------------------------------------------
// serial_rx_status_fifo
// Receive side of a 6850-style serial port, fed from a byte ring in RAM.
// ---------------------------------------------------------------------------
//  channel | valid        | stall        | payload
//  --------+--------------+--------------+--------------------------
//  in      | i_in_valid   | o_in_stall   | i_in_item  (t_in_item)
//  out     | o_out_valid  | i_out_stall  | o_out_item (t_out_item)
//  cfg     | i_cfg_we     | -            | i_cfg_data (feed gap)
//
// One item per cycle while o_in_stall is low; its result is registered.
// The ring RAM is read every cycle at the next tail address (write data
// forwarded on a same-entry write), so a tick finds the oldest byte ready.
// A two-entry output stage (output register plus skid) lets input run on
// while the output is stalled; o_in_stall rises only when the skid is full.
// Reset is synchronous; the ring contents are not cleared, no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none

`include "serial_rx_status_fifo_defines.svh"

module serial_rx_status_fifo (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_in_valid,
    output logic                    o_in_stall,
    input  srx_fifo_pkg::t_in_item  i_in_item,
    output logic                    o_out_valid,
    input  wire                     i_out_stall,
    output srx_fifo_pkg::t_out_item o_out_item,
    input  wire                     i_cfg_we,
    input  wire  [15:0]             i_cfg_data
);

    localparam int AW = srx_fifo_pkg::RING_AW;

    logic [7:0]    r_ring [srx_fifo_pkg::RING_DEPTH];
    logic [7:0]    r_rd_data;

    logic [15:0]   r_feed_gap;
    logic [7:0]    r_ctrl,    n_ctrl;
    logic [7:0]    r_rx_data, n_rx_data;
    logic          r_rx_full, n_rx_full;
    logic [AW-1:0] r_head,    n_head;
    logic [AW-1:0] r_tail,    n_tail;
    logic [15:0]   r_gap,     n_gap;

    logic          r_out_valid;
    srx_fifo_pkg::t_out_item r_out;
    logic          r_skid_valid;
    srx_fifo_pkg::t_out_item r_skid;

    srx_fifo_pkg::t_out_item n_res;
    logic          in_acc;
    logic          out_take;
    logic          ring_we;
    logic [AW-1:0] head_nxt;

    assign in_acc   = i_in_valid && !r_skid_valid;
    assign out_take = r_out_valid && !i_out_stall;
    assign head_nxt = srx_fifo_pkg::ring_next(r_head);

    // Request decode and state update
    always_comb begin
        n_ctrl    = r_ctrl;
        n_rx_data = r_rx_data;
        n_rx_full = r_rx_full;
        n_head    = r_head;
        n_tail    = r_tail;
        n_gap     = r_gap;
        ring_we   = 1'b0;
        n_res     = '0;
        if (in_acc) begin
            unique case (i_in_item.req_type)
                srx_fifo_pkg::REQ_TICK: begin
                    if (r_gap != 16'd0) begin
                        n_gap = r_gap - 16'd1;
                    end else if (!r_rx_full && (r_head != r_tail)) begin
                        n_rx_data = r_rd_data;
                        n_tail    = srx_fifo_pkg::ring_next(r_tail);
                        n_rx_full = 1'b1;
                        n_gap     = r_feed_gap;
                    end
                end
                srx_fifo_pkg::REQ_STATUS: begin
                    n_res.read_value = srx_fifo_pkg::STAT_TDRE;
                    if (r_rx_full) begin
                        n_res.read_value = n_res.read_value | srx_fifo_pkg::STAT_RDRF;
                    end
                    if (r_rx_full && r_ctrl[srx_fifo_pkg::CTRL_RIE_BIT]) begin
                        n_res.read_value = n_res.read_value | srx_fifo_pkg::STAT_IRQ;
                    end
                end
                srx_fifo_pkg::REQ_DATA_RD: begin
                    n_res.read_value = r_rx_data;
                    n_rx_full        = 1'b0;
                end
                srx_fifo_pkg::REQ_CTRL_WR: begin
                    n_ctrl = i_in_item.bus_data;
                    if (i_in_item.bus_data[1:0] == srx_fifo_pkg::CTRL_MASTER_RST) begin
                        n_rx_full = 1'b0;
                    end
                end
                srx_fifo_pkg::REQ_DATA_WR: begin
                    // transmit side not modeled
                end
                srx_fifo_pkg::REQ_PUSH: begin
                    if (head_nxt == r_tail) begin
                        n_res.push_dropped = 1'b1;
                    end else begin
                        ring_we = 1'b1;
                        n_head  = head_nxt;
                    end
                end
                default: begin
                    // unused codes: no effect
                end
            endcase
            n_res.irq = n_rx_full && n_ctrl[srx_fifo_pkg::CTRL_RIE_BIT];
        end
    end

    // Ring RAM: one write port, one registered read at the next tail
    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            r_ring[r_head] <= i_in_item.bus_data;
        end
        if (ring_we && (r_head == n_tail)) begin
            r_rd_data <= i_in_item.bus_data;
        end else begin
            r_rd_data <= r_ring[n_tail];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_feed_gap <= srx_fifo_pkg::FEED_GAP_RESET;
            r_ctrl     <= srx_fifo_pkg::CTRL_RESET_VAL;
            r_rx_data  <= '0;
            r_rx_full  <= 1'b0;
            r_head     <= '0;
            r_tail     <= '0;
            r_gap      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_feed_gap <= i_cfg_data;
            end
            r_ctrl    <= n_ctrl;
            r_rx_data <= n_rx_data;
            r_rx_full <= n_rx_full;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_gap     <= n_gap;
        end
    end

    // Output register with skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (out_take) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end
            end else if (in_acc) begin
                if (r_out_valid && !out_take) begin
                    r_skid_valid <= 1'b1;
                end else begin
                    r_out_valid <= 1'b1;
                end
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out <= r_skid;
            end
        end else if (in_acc) begin
            if (r_out_valid && !out_take) begin
                r_skid <= n_res;
            end else begin
                r_out <= n_res;
            end
        end
    end

    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    `SRX_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid,
        "skid holds an item while the output register is empty")
    `SRX_ASSERT_NOW(a_rdrf_clear_cause, i_clk, i_rst_n,
        $fell(r_rx_full) && $past(i_rst_n),
        $past(in_acc) && ($past(i_in_item.req_type) == srx_fifo_pkg::REQ_DATA_RD ||
        ($past(i_in_item.req_type) == srx_fifo_pkg::REQ_CTRL_WR &&
        $past(i_in_item.bus_data[1:0]) == srx_fifo_pkg::CTRL_MASTER_RST)),
        "RDRF cleared without data read or master reset")
    `SRX_ASSERT_NOW(a_tail_move_reload, i_clk, i_rst_n,
        $past(i_rst_n) && (r_tail != $past(r_tail)),
        r_rx_full && (r_gap == $past(r_feed_gap)),
        "ring tail advanced without loading data register and reloading gap")

endmodule

`default_nettype wire
